// ===== design/wsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared codes and control bundles for the window peak SNR gate.
// ----------------------------------------------------------------------------
package wsg_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int WIN_BITS       = 16;
   localparam int MIN_BITS       = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_START  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_END    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNAL_START = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNAL_END   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RATIO    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_EN     = 3'd5;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOISE_ZERO = 2'd1;
   localparam logic [1:0] STATUS_BOTH_ZERO  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY      = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic sample_take;   // non-final item: update window peaks
      logic trace_end;     // final item: capture peaks, load divider, clear trace
      logic div_step;      // one quotient bit
      logic out_load;      // build result and load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;      // current step produces the last quotient bit
   } stat_type;

endpackage

// ===== design/window_peak_snr_gate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_peak_snr_gate_unit
// Peak-amplitude signal-to-noise gate over two sample windows of a trace.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one trace sample per item; req_last marks the final item,
//    which is never counted in either window and closes the trace.
//  - Sample numbering starts at zero after reset and after every final item.
//  - Non-final items are accepted back to back whenever req_ready is high.
//  - A final item starts a bit-serial divider for a SAMPLE_BITS+FRAC_BITS-bit
//    quotient, one quotient bit per cycle; the result is then built and
//    registered once the output register is free, and appears on rsp_*.
//  - req_ready is low while the divider runs and while a finished result
//    waits for a busy output register.
//  - A result held in the output register does not block new samples; if the
//    receiver stalls, the next result waits in the divider until it is taken.
//  - csr_* writes are taken at once; write only while the block is idle.
//  - Reset clears the configuration registers to zero, the trace state and rsp_valid.
// ----------------------------------------------------------------------------
module window_peak_snr_gate_unit #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [wsg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_BITS+FRAC_BITS:0]   rsp_ratio_q16,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_accepted
);

   wsg_pkg::cmd_type  cmd;
   wsg_pkg::stat_type stat;

   wsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   wsg_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_sample),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ratio_q16 (rsp_ratio_q16),
      .rsp_status    (rsp_status),
      .rsp_accepted  (rsp_accepted)
   );

endmodule

// ===== design/wsg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_ctrl
// Sequencer: takes items, runs the divider after the final item and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module wsg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wsg_pkg::cmd_type   cmd,
   input  wsg_pkg::stat_type  stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.sample_take  = 1'b0;
      cmd.trace_end    = 1'b0;
      cmd.div_step     = 1'b0;
      cmd.out_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_last) begin
                  cmd.trace_end = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  cmd.sample_take = 1'b1;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold the finished quotient until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_starts_div: assert property (@(posedge clock) disable iff (reset)
      (take && req_last) |=> (state_ff == S_DIV))
      else $error("final item did not start the divider");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_div_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && stat.div_done) |=>
         (state_ff == S_FIN && rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("divider completion not followed by result stage");

   a_one_result_per_trace: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result load did not raise valid");

endmodule

// ===== design/wsg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_datapath
// Configuration registers, window peak trackers, bit-serial restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module wsg_datapath #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [wsg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   input  wsg_pkg::cmd_type                        cmd,
   output wsg_pkg::stat_type                       stat,
   output logic signed [SAMPLE_BITS+FRAC_BITS:0]   rsp_ratio_q16,
   output logic [1:0]                              rsp_status,
   output logic                                    rsp_accepted
);

   localparam int IDX_W   = $clog2(MAX_SAMPLES);
   localparam int WIN_W   = (IDX_W > wsg_pkg::WIN_BITS) ? IDX_W : wsg_pkg::WIN_BITS;
   localparam int Q_W     = SAMPLE_BITS + FRAC_BITS;
   localparam int OUT_W   = Q_W + 1;
   localparam int CNT_W   = $clog2(Q_W);
   localparam int R_UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int M_UP    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int CMP_A   = OUT_W + R_UP;
   localparam int CMP_B   = wsg_pkg::MIN_BITS + M_UP;
   localparam int CMP_W   = (CMP_A > CMP_B) ? CMP_A : CMP_B;

   // configuration
   logic [wsg_pkg::WIN_BITS-1:0] noise_start_ff, noise_end_ff;
   logic [wsg_pkg::WIN_BITS-1:0] signal_start_ff, signal_end_ff;
   logic [wsg_pkg::MIN_BITS-1:0] min_ratio_ff;
   logic                         check_en_ff;

   // trace state
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0] noise_peak_ff, noise_peak_in;
   logic [SAMPLE_BITS-1:0] signal_peak_ff, signal_peak_in;
   logic                   noise_seen_ff, noise_seen_in;
   logic                   signal_seen_ff, signal_seen_in;

   // captured at trace end
   logic [SAMPLE_BITS-1:0] snap_noise_ff, snap_signal_ff;
   logic                   snap_nseen_ff, snap_sseen_ff;

   // divider
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SAMPLE_BITS:0]   rem_sh;
   logic [SAMPLE_BITS:0]   rem_sub;
   logic                   ge;

   // result
   logic signed [OUT_W-1:0] ratio_ff, ratio_in;
   logic [1:0]              status_ff, status_in;
   logic                    acc_ff, acc_in;

   logic [SAMPLE_BITS-1:0] mag;
   logic [WIN_W-1:0]       idx_w;
   logic                   in_noise, in_signal;
   logic [OUT_W-1:0]       quo_ext;
   logic [CMP_W-1:0]       lhs, rhs;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_start_ff  <= '0;
         noise_end_ff    <= '0;
         signal_start_ff <= '0;
         signal_end_ff   <= '0;
         min_ratio_ff    <= '0;
         check_en_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            wsg_pkg::CSR_NOISE_START:  noise_start_ff  <= csr_wdata[wsg_pkg::WIN_BITS-1:0];
            wsg_pkg::CSR_NOISE_END:    noise_end_ff    <= csr_wdata[wsg_pkg::WIN_BITS-1:0];
            wsg_pkg::CSR_SIGNAL_START: signal_start_ff <= csr_wdata[wsg_pkg::WIN_BITS-1:0];
            wsg_pkg::CSR_SIGNAL_END:   signal_end_ff   <= csr_wdata[wsg_pkg::WIN_BITS-1:0];
            wsg_pkg::CSR_MIN_RATIO:    min_ratio_ff    <= csr_wdata[wsg_pkg::MIN_BITS-1:0];
            wsg_pkg::CSR_CHECK_EN:     check_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // magnitude of the most negative code fits unsigned in the same width
   assign mag   = req_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_sample) : req_sample;
   assign idx_w = WIN_W'(idx_ff);
   assign in_noise  = (idx_w >= WIN_W'(noise_start_ff)) && (idx_w < WIN_W'(noise_end_ff));
   assign in_signal = (idx_w >= WIN_W'(signal_start_ff)) && (idx_w < WIN_W'(signal_end_ff));

   always_comb begin
      idx_in         = idx_ff;
      noise_peak_in  = noise_peak_ff;
      signal_peak_in = signal_peak_ff;
      noise_seen_in  = noise_seen_ff;
      signal_seen_in = signal_seen_ff;
      if (cmd.trace_end) begin
         idx_in         = '0;
         noise_peak_in  = '0;
         signal_peak_in = '0;
         noise_seen_in  = 1'b0;
         signal_seen_in = 1'b0;
      end else if (cmd.sample_take) begin
         if (in_noise) begin
            if (!noise_seen_ff || mag > noise_peak_ff) begin
               noise_peak_in = mag;
            end
            noise_seen_in = 1'b1;
         end
         if (in_signal) begin
            if (!signal_seen_ff || mag > signal_peak_ff) begin
               signal_peak_in = mag;
            end
            signal_seen_in = 1'b1;
         end
         if (idx_ff != IDX_W'(MAX_SAMPLES - 1)) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         noise_peak_ff  <= '0;
         signal_peak_ff <= '0;
         noise_seen_ff  <= 1'b0;
         signal_seen_ff <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         noise_peak_ff  <= noise_peak_in;
         signal_peak_ff <= signal_peak_in;
         noise_seen_ff  <= noise_seen_in;
         signal_seen_ff <= signal_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trace_end) begin
         snap_noise_ff  <= noise_peak_ff;
         snap_signal_ff <= signal_peak_ff;
         snap_nseen_ff  <= noise_seen_ff;
         snap_sseen_ff  <= signal_seen_ff;
      end
   end

   // restoring division, one quotient bit per step, dividend shifts out of quo
   assign rem_sh  = {rem_ff, quo_ff[Q_W-1]};
   assign ge      = rem_sh >= {1'b0, snap_noise_ff};
   assign rem_sub = rem_sh - {1'b0, snap_noise_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.trace_end) begin
         rem_in = '0;
         cnt_in = '0;
         // empty signal window divides one by the noise peak
         quo_in = signal_seen_ff ? {signal_peak_ff, FRAC_BITS'(0)} : (Q_W'(1) << FRAC_BITS);
      end else if (cmd.div_step) begin
         rem_in = ge ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
         quo_in = {quo_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign stat.div_done = (cnt_ff == CNT_W'(Q_W - 1));

   assign quo_ext = {1'b0, quo_ff};

   always_comb begin
      if (!snap_nseen_ff || !snap_sseen_ff) begin
         status_in = wsg_pkg::STATUS_EMPTY;
         if (!snap_nseen_ff && !snap_sseen_ff) begin
            ratio_in = OUT_W'(1) << FRAC_BITS;
         end else if (!snap_nseen_ff) begin
            ratio_in = -$signed({1'b0, snap_signal_ff, FRAC_BITS'(0)});
         end else if (snap_noise_ff == '0) begin
            ratio_in = -$signed(OUT_W'(1) << (SAMPLE_BITS - 1 + FRAC_BITS));
         end else begin
            ratio_in = -$signed(quo_ext);
         end
      end else if (snap_noise_ff == '0) begin
         if (snap_signal_ff == '0) begin
            status_in = wsg_pkg::STATUS_BOTH_ZERO;
            ratio_in  = '0;
         end else begin
            status_in = wsg_pkg::STATUS_NOISE_ZERO;
            ratio_in  = $signed(OUT_W'(1) << (SAMPLE_BITS - 1 + FRAC_BITS));
         end
      end else begin
         status_in = wsg_pkg::STATUS_OK;
         ratio_in  = $signed(quo_ext);
      end
   end

   // compare in a common scale of 2^-max(FRAC_BITS,16)
   assign lhs = CMP_W'(ratio_in) << R_UP;
   assign rhs = CMP_W'(min_ratio_ff) << M_UP;

   always_comb begin
      if (!check_en_ff || min_ratio_ff == '0 || status_in == wsg_pkg::STATUS_BOTH_ZERO) begin
         acc_in = 1'b1;
      end else if (ratio_in[OUT_W-1]) begin
         acc_in = 1'b0;
      end else begin
         acc_in = (lhs >= rhs);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ratio_ff  <= ratio_in;
         status_ff <= status_in;
         acc_ff    <= acc_in;
      end
   end

   assign rsp_ratio_q16 = ratio_ff;
   assign rsp_status    = status_ff;
   assign rsp_accepted  = acc_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for window_peak_snr_gate_unit.
// Feeds sample traces through the req_ channel, mirrors the window peak
// tracking and the Q16 ratio, status and threshold decision in a local
// model, and compares every rsp_ item in order against that model.
// ----------------------------------------------------------------------------
module tb;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 16;
   localparam int RATIO_BITS    = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int IDLE_PCT      = 37;

   localparam longint RATIO_ONE = longint'(1) <<< FRAC_BITS;
   localparam longint RATIO_SAT = longint'(1) <<< (SAMPLE_BITS - 1 + FRAC_BITS);

   localparam logic [wsg_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [wsg_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [RATIO_BITS-1:0] ratio;
      logic [1:0]                   status;
      logic                         accepted;
   } snr_result_type;

   logic                                  clock;
   logic                                  reset      = 1'b1;
   logic                                  csr_we     = 1'b0;
   logic [wsg_pkg::CSR_INDEX_BITS-1:0]    csr_index  = '0;
   logic [wsg_pkg::CSR_DATA_BITS-1:0]     csr_wdata  = '0;
   logic                                  req_valid  = 1'b0;
   logic                                  req_ready;
   logic signed [SAMPLE_BITS-1:0]         req_sample = '0;
   logic                                  req_last   = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready  = 1'b0;
   logic signed [RATIO_BITS-1:0]          rsp_ratio_q16;
   logic [1:0]                            rsp_status;
   logic                                  rsp_accepted;

   // model copy of the registers and the trace state
   logic [15:0]             noise_lo    = '0;
   logic [15:0]             noise_hi    = '0;
   logic [15:0]             signal_lo   = '0;
   logic [15:0]             signal_hi   = '0;
   logic [31:0]             min_ratio   = '0;
   logic                    check_on    = 1'b0;
   logic [15:0]             trace_index = '0;
   logic [SAMPLE_BITS-1:0]  noise_peak  = '0;
   logic [SAMPLE_BITS-1:0]  signal_peak = '0;
   logic                    noise_hit   = 1'b0;
   logic                    signal_hit  = 1'b0;

   snr_result_type snr_results_due[$];
   int idle_pct    = IDLE_PCT;
   int fail_count  = 0;
   int cycle_count = 0;

   window_peak_snr_gate_unit dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ratio_q16 (rsp_ratio_q16),
      .rsp_status    (rsp_status),
      .rsp_accepted  (rsp_accepted)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void store_reg(logic [wsg_pkg::CSR_INDEX_BITS-1:0] idx,
                                     logic [31:0] data);
      case (idx)
         wsg_pkg::CSR_NOISE_START:  noise_lo  = data[15:0];
         wsg_pkg::CSR_NOISE_END:    noise_hi  = data[15:0];
         wsg_pkg::CSR_SIGNAL_START: signal_lo = data[15:0];
         wsg_pkg::CSR_SIGNAL_END:   signal_hi = data[15:0];
         wsg_pkg::CSR_MIN_RATIO:    min_ratio = data;
         wsg_pkg::CSR_CHECK_EN:     check_on  = data[0];
         default: ;
      endcase
   endfunction

   function automatic void track_sample(logic signed [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] mag;
      mag = s[SAMPLE_BITS-1] ? ~s + 1'b1 : s;
      if (trace_index >= noise_lo && trace_index < noise_hi) begin
         if (!noise_hit || mag > noise_peak) noise_peak = mag;
         noise_hit = 1'b1;
      end
      if (trace_index >= signal_lo && trace_index < signal_hi) begin
         if (!signal_hit || mag > signal_peak) signal_peak = mag;
         signal_hit = 1'b1;
      end
      // index sticks at the top instead of wrapping
      if (trace_index != 16'hFFFF) trace_index = trace_index + 1'b1;
   endfunction

   function automatic snr_result_type close_trace();
      snr_result_type res;
      longint         r;
      logic [1:0]     st;
      if (!noise_hit || !signal_hit) begin
         st = wsg_pkg::STATUS_EMPTY;
         if (!noise_hit && !signal_hit) r = RATIO_ONE;
         else if (!noise_hit) r = -(longint'(signal_peak) <<< FRAC_BITS);
         else if (noise_peak == 0) r = -RATIO_SAT;
         else r = -(RATIO_ONE / longint'(noise_peak));
      end else if (noise_peak == 0) begin
         st = (signal_peak == 0) ? wsg_pkg::STATUS_BOTH_ZERO : wsg_pkg::STATUS_NOISE_ZERO;
         r  = (signal_peak == 0) ? 0 : RATIO_SAT;
      end else begin
         st = wsg_pkg::STATUS_OK;
         r  = (longint'(signal_peak) <<< FRAC_BITS) / longint'(noise_peak);
      end
      res.ratio  = r[RATIO_BITS-1:0];
      res.status = st;
      if (!check_on || min_ratio == 0 || st == wsg_pkg::STATUS_BOTH_ZERO) res.accepted = 1'b1;
      else if (r < 0) res.accepted = 1'b0;
      else res.accepted = (r >= longint'(min_ratio));
      trace_index = '0;
      noise_peak  = '0;
      signal_peak = '0;
      noise_hit   = 1'b0;
      signal_hit  = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      snr_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (snr_results_due.size() == 0) begin
            $display("%0t: result with none pending, expected nothing got ratio %0d status %0d",
                     $time, rsp_ratio_q16, rsp_status);
            fail_count++;
         end else begin
            want = snr_results_due.pop_front();
            check_field("ratio_q16", want.ratio, rsp_ratio_q16);
            check_field("status", want.status, rsp_status);
            check_field("accepted", want.accepted, rsp_accepted);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready   <= ($urandom_range(99) >= idle_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic last_flag);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (last_flag) snr_results_due.push_back(close_trace());
      else track_sample(s);
   endtask

   // one noise item, one signal item, then the closing item
   task automatic send_trace(input logic signed [SAMPLE_BITS-1:0] a, b, tail);
      send_item(a, 1'b0);
      send_item(b, 1'b0);
      send_item(tail, 1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (snr_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wsg_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_reg(idx, data);
   endtask

   // unused upper bits carry junk; the spare indexes must be ignored
   task automatic write_settings(input logic [15:0] nlo, nhi, slo, shi,
                                 input logic [31:0] min, input logic chk);
      wait_idle();
      write_reg(CSR_SPARE_LO, $urandom());
      write_reg(wsg_pkg::CSR_NOISE_START, ($urandom() & 32'hFFFF0000) | nlo);
      write_reg(wsg_pkg::CSR_NOISE_END, ($urandom() & 32'hFFFF0000) | nhi);
      write_reg(wsg_pkg::CSR_SIGNAL_START, ($urandom() & 32'hFFFF0000) | slo);
      write_reg(wsg_pkg::CSR_SIGNAL_END, ($urandom() & 32'hFFFF0000) | shi);
      write_reg(wsg_pkg::CSR_MIN_RATIO, min);
      write_reg(wsg_pkg::CSR_CHECK_EN, ($urandom() & 32'hFFFFFFFE) | chk);
      write_reg(CSR_SPARE_HI, $urandom());
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random picks

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample(int zero_pct);
      logic signed [SAMPLE_BITS-1:0] v;
      if ($urandom_range(99) < zero_pct) return '0;
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_BITS'($urandom());
         default: begin
            v = SAMPLE_BITS'($urandom_range(300));
            return $urandom_range(1) ? -v : v;
         end
      endcase
   endfunction

   function automatic void pick_window(output logic [15:0] lo, output logic [15:0] hi);
      case ($urandom_range(9))
         0: begin lo = 16'($urandom()); hi = 16'($urandom()); end
         1: begin lo = 16'($urandom_range(30)); hi = 16'hFFFF; end
         2: begin lo = 16'($urandom_range(30)); hi = 16'($urandom_range(30)); end
         default: begin
            lo = 16'($urandom_range(20));
            hi = lo + 16'($urandom_range(1, 12));
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_min();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'hFFFFFFFF;
         2: return $urandom();
         default: return $urandom_range(32'h0004_0000);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      // all configuration registers zero after reset: both windows empty
      send_trace(24'sd5, -24'sd3, 24'sd7);
      send_item(24'sd1, 1'b1);
   endtask

   task automatic test_ratio_cases();
      write_settings(16'd0, 16'd1, 16'd1, 16'd2, 32'd0, 1'b0);
      send_trace(SAMPLE_MIN, SAMPLE_MAX, -24'sd1);
      send_trace(24'sd0, 24'sd100, 24'sd9);
      send_trace(24'sd0, 24'sd0, SAMPLE_MAX);
   endtask

   task automatic test_thresholds();
      write_settings(16'd0, 16'd1, 16'd1, 16'd2, 32'h0002_0000, 1'b1);
      send_trace(24'sd2, -24'sd4, 24'sd0);
      send_trace(-24'sd2, 24'sd3, 24'sd0);
      send_trace(24'sd0, 24'sd0, 24'sd0);
   endtask

   task automatic test_empty_windows();
      // reversed noise window, ratio goes negative and fails the check
      write_settings(16'd3, 16'd1, 16'd1, 16'd2, 32'hFFFF_FFFF, 1'b1);
      send_trace(24'sd6, -24'sd9, 24'sd2);
      // widest noise window, signal window reversed at the top
      write_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'd1, 1'b1);
      send_trace(-24'sd4, 24'sd2, 24'sd0);
      send_trace(24'sd0, 24'sd0, -24'sd8);
   endtask

   task automatic test_random_traces();
      int sent;
      int phase;
      int t;
      int len;
      int zero_pct;
      logic [15:0] nlo, nhi, slo, shi;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_pct = (phase >= 8 && phase < 12) ? 0 : IDLE_PCT;
         pick_window(nlo, nhi);
         pick_window(slo, shi);
         write_settings(nlo, nhi, slo, shi, pick_min(), 1'($urandom_range(1)));
         for (t = 0; t < 6; t++) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 30);
            case ($urandom_range(5))
               0: zero_pct = 90;
               1: zero_pct = 30;
               default: zero_pct = 0;
            endcase
            repeat (len) send_item(random_sample(zero_pct), 1'b0);
            send_item(random_sample(zero_pct), 1'b1);
            sent += len + 1;
         end
         phase++;
      end
      idle_pct = IDLE_PCT;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_ratio_cases();
      test_thresholds();
      test_empty_windows();
      test_random_traces();
      wait_idle();
      if (fail_count == 0 && snr_results_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
